/* rtl/bsc_pkg.sv */
// Shared types and constants for the banker's safety check engine.
// No dependencies.
package bsc_pkg;

  localparam logic [2:0] CMD_LOAD_ALLOC = 3'd0;
  localparam logic [2:0] CMD_LOAD_MAX   = 3'd1;
  localparam logic [2:0] CMD_LOAD_AVAIL = 3'd2;
  localparam logic [2:0] CMD_CHECK      = 3'd3;
  localparam logic [2:0] CMD_REQUEST    = 3'd4;

  localparam logic [1:0] KIND_SAFE   = 2'd0;
  localparam logic [1:0] KIND_UNSAFE = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [1:0] CFG_NUM_PROCS = 2'd0;
  localparam logic [1:0] CFG_NUM_RES   = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRANT,
    ST_SCAN,
    ST_EMIT,
    ST_ONE
  } state_t;

  // Control broadcast from the sequencer to every process cell.
  typedef struct packed {
    logic load_alloc;
    logic load_max;
    logic grant;
    logic clear_fin;
    logic visit;
  } cell_ctl_t;

endpackage

/* rtl/bsc_cell.sv */
// One process cell: holds that process's allocation and need rows and its finish flag.
// Depends on bsc_pkg.
module bsc_cell #(
  parameter int MAX_RES    = 4,
  parameter int COUNT_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bsc_pkg::cell_ctl_t                  ctl,
  input  logic                                sel,
  input  logic [$clog2(MAX_RES+1)-1:0]        res_cnt,
  input  logic [((MAX_RES>1)?$clog2(MAX_RES):1)-1:0] res_idx,
  input  logic [COUNT_BITS-1:0]               amount,
  input  logic [MAX_RES-1:0][COUNT_BITS-1:0]  req,
  input  logic [MAX_RES-1:0][COUNT_BITS-1:0]  work,
  output logic [MAX_RES-1:0][COUNT_BITS-1:0]  need_o,
  output logic [MAX_RES-1:0][COUNT_BITS-1:0]  work_o,
  output logic                                fits_o
);

  localparam logic [COUNT_BITS:0] CMAX = {1'b0, {COUNT_BITS{1'b1}}};

  logic [MAX_RES-1:0][COUNT_BITS-1:0] alloc_r, need_r;
  logic                               fin_r;
  logic [MAX_RES-1:0]                 ok;
  logic [MAX_RES-1:0][COUNT_BITS:0]   asum, wsum;

  always_comb begin
    for (int j = 0; j < MAX_RES; j++) begin
      ok[j]   = (j >= int'(res_cnt)) || (need_r[j] <= work[j]);
      asum[j] = {1'b0, alloc_r[j]} + {1'b0, req[j]};
      wsum[j] = {1'b0, work[j]} + {1'b0, alloc_r[j]};
      work_o[j] = work[j];
      if (j < int'(res_cnt))
        work_o[j] = (wsum[j] > CMAX) ? {COUNT_BITS{1'b1}} : wsum[j][COUNT_BITS-1:0];
    end
  end

  assign fits_o = !fin_r && (&ok);
  assign need_o = need_r;

  // Load rows, apply a grant, clear or mark finished
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
      need_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      if (sel && ctl.load_alloc) alloc_r[res_idx] <= amount;
      if (sel && ctl.load_max)
        need_r[res_idx] <= (amount > alloc_r[res_idx]) ? amount - alloc_r[res_idx] : '0;
      if (sel && ctl.grant) begin
        for (int j = 0; j < MAX_RES; j++) begin
          if (j < int'(res_cnt)) begin
            alloc_r[j] <= (asum[j] > CMAX) ? {COUNT_BITS{1'b1}} : asum[j][COUNT_BITS-1:0];
            need_r[j]  <= need_r[j] - req[j];
          end
        end
      end
      if (ctl.clear_fin) fin_r <= 1'b0;
      else if (sel && ctl.visit && fits_o) fin_r <= 1'b1;
    end
  end

endmodule

/* rtl/bankers_safety_check.sv */
// Top level of the banker's safety check engine: command decode, sequencer, cell row.
// Depends on bsc_pkg and bsc_cell.
//
//  channel | ports                                   | direction
//  in      | in_valid in_stall in_cmd in_proc in_res in_amount in_last | into block
//  out     | out_valid out_stall out_kind out_proc_id out_last_res     | out of block
//  cfg     | cfg_we cfg_index cfg_data                                 | into block
//
// A check visits one cell a cycle through the row until all processes finish or a
// full lap finds none that fits, then gives one result beat per cycle while out_stall
// is low; a valid final request is granted first. Reset is synchronous and clears
// all tables. A stalled result holds; no new item is taken until a run is delivered.
module bankers_safety_check #(
  parameter int MAX_PROCS  = 8,
  parameter int MAX_RES    = 4,
  parameter int COUNT_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [2:0] in_proc,
  input  logic [1:0] in_res,
  input  logic [7:0] in_amount,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [2:0] out_proc_id,
  output logic       out_last_res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int PB = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RB = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int PC = $clog2(MAX_PROCS + 1);
  localparam int RC = $clog2(MAX_RES + 1);

  logic [3:0] nprocs_r;
  logic [2:0] nres_r;
  logic [PC-1:0] np;
  logic [RC-1:0] nr;

  // Clamp register values into the legal range
  always_comb begin
    if (nprocs_r == 4'd0) np = PC'(1);
    else if ({28'd0, nprocs_r} > MAX_PROCS) np = PC'(MAX_PROCS);
    else np = PC'(nprocs_r);
    if (nres_r == 3'd0) nr = RC'(1);
    else if ({29'd0, nres_r} > MAX_RES) nr = RC'(MAX_RES);
    else nr = RC'(nres_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nprocs_r <= 4'd8;
      nres_r   <= 3'd4;
    end else if (cfg_we) begin
      if (cfg_index == bsc_pkg::CFG_NUM_PROCS) nprocs_r <= cfg_data;
      else if (cfg_index == bsc_pkg::CFG_NUM_RES) nres_r <= cfg_data[2:0];
    end
  end

  bsc_pkg::state_t state_r, state_nxt;
  logic [MAX_RES-1:0][COUNT_BITS-1:0] avail_r, work_r, req_r, work_nxt;
  logic [MAX_PROCS-1:0][PB-1:0] order_r;
  logic [PB-1:0] cur_r, req_p_r;
  logic [PC-1:0] count_r, idle_r, emit_r;
  logic [1:0]    one_kind_r;
  logic [MAX_PROCS-1:0] fits;
  logic [MAX_PROCS-1:0][MAX_RES-1:0][COUNT_BITS-1:0] cell_need, cell_work;
  bsc_pkg::cell_ctl_t ctl;

  logic acc;
  logic pin, rin;
  logic [COUNT_BITS-1:0] amt;
  logic [MAX_RES-1:0][COUNT_BITS-1:0] req_now;
  logic req_bad;
  logic cur_fit;
  logic scan_done;

  assign acc = in_valid && !in_stall;
  assign pin = {29'd0, in_proc} < MAX_PROCS;
  assign rin = {30'd0, in_res} < MAX_RES;
  assign amt = COUNT_BITS'(in_amount & 8'(((1 << COUNT_BITS) - 1) & 8'hff));

  // Request vector with the current element merged in, and its reject check
  always_comb begin
    req_now = req_r;
    if (rin) req_now[RB'(in_res)] = amt;
    req_bad = ({29'd0, in_proc} >= int'(np));
    for (int j = 0; j < MAX_RES; j++)
      if (j < int'(nr) && (req_now[j] > cell_need[PB'(in_proc)][j] || req_now[j] > avail_r[j]))
        req_bad = 1'b1;
  end

  assign cur_fit = fits[cur_r];
  assign work_nxt = cell_work[cur_r];
  assign scan_done = (count_r == np) || (idle_r == np);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsc_pkg::ST_IDLE:
        if (acc && in_cmd == bsc_pkg::CMD_CHECK) state_nxt = bsc_pkg::ST_SCAN;
        else if (acc && in_cmd == bsc_pkg::CMD_REQUEST && in_last)
          state_nxt = req_bad ? bsc_pkg::ST_ONE : bsc_pkg::ST_GRANT;
      bsc_pkg::ST_GRANT: state_nxt = bsc_pkg::ST_SCAN;
      bsc_pkg::ST_SCAN:
        if (scan_done) state_nxt = (count_r == np) ? bsc_pkg::ST_EMIT : bsc_pkg::ST_ONE;
      bsc_pkg::ST_EMIT:
        if (!out_stall && emit_r + PC'(1) == np) state_nxt = bsc_pkg::ST_IDLE;
      bsc_pkg::ST_ONE:
        if (!out_stall) state_nxt = bsc_pkg::ST_IDLE;
      default: state_nxt = bsc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and cell controls
  always_comb begin
    in_stall     = (state_r != bsc_pkg::ST_IDLE);
    out_valid    = (state_r == bsc_pkg::ST_EMIT) || (state_r == bsc_pkg::ST_ONE);
    out_kind     = (state_r == bsc_pkg::ST_EMIT) ? bsc_pkg::KIND_SAFE : one_kind_r;
    out_proc_id  = (state_r == bsc_pkg::ST_EMIT) ? 3'(order_r[emit_r[PB-1:0]]) : 3'd0;
    out_last_res = (state_r == bsc_pkg::ST_ONE) || (emit_r + PC'(1) == np);
    ctl.load_alloc = acc && in_cmd == bsc_pkg::CMD_LOAD_ALLOC && pin && rin;
    ctl.load_max   = acc && in_cmd == bsc_pkg::CMD_LOAD_MAX && pin && rin;
    ctl.grant      = (state_r == bsc_pkg::ST_GRANT);
    ctl.clear_fin  = acc && (in_cmd == bsc_pkg::CMD_CHECK || in_cmd == bsc_pkg::CMD_REQUEST);
    ctl.visit      = (state_r == bsc_pkg::ST_SCAN) && !scan_done;
  end

  // Datapath registers of the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsc_pkg::ST_IDLE;
      avail_r <= '0;
      cur_r   <= '0;
      count_r <= '0;
      idle_r  <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        bsc_pkg::ST_IDLE: begin
          if (acc && in_cmd == bsc_pkg::CMD_LOAD_AVAIL && rin) avail_r[RB'(in_res)] <= amt;
          if (acc && in_cmd == bsc_pkg::CMD_REQUEST) begin
            req_r   <= req_now;
            req_p_r <= PB'(in_proc);
          end
          one_kind_r <= bsc_pkg::KIND_REJECT;
          work_r  <= avail_r;
          cur_r   <= '0;
          count_r <= '0;
          idle_r  <= '0;
          emit_r  <= '0;
        end
        bsc_pkg::ST_GRANT: begin
          for (int j = 0; j < MAX_RES; j++)
            if (j < int'(nr)) avail_r[j] <= avail_r[j] - req_r[j];
          for (int j = 0; j < MAX_RES; j++)
            if (j < int'(nr)) work_r[j] <= avail_r[j] - req_r[j];
        end
        bsc_pkg::ST_SCAN: begin
          one_kind_r <= bsc_pkg::KIND_UNSAFE;
          if (!scan_done) begin
            if (cur_fit) begin
              work_r <= work_nxt;
              order_r[count_r[PB-1:0]] <= cur_r;
              count_r <= count_r + PC'(1);
              idle_r  <= '0;
            end else begin
              idle_r <= idle_r + PC'(1);
            end
            cur_r <= ({{(32-PC){1'b0}}, PC'(cur_r) + PC'(1)} >= int'(np)) ? '0 : cur_r + PB'(1);
          end
        end
        bsc_pkg::ST_EMIT:
          if (!out_stall) emit_r <= emit_r + PC'(1);
        bsc_pkg::ST_ONE: ;
        default: ;
      endcase
    end
  end

  // Row of process cells
  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    logic sel;
    always_comb begin
      if (state_r == bsc_pkg::ST_IDLE) sel = ({29'd0, in_proc} == g);
      else if (state_r == bsc_pkg::ST_GRANT) sel = (req_p_r == PB'(g));
      else sel = (cur_r == PB'(g));
    end
    bsc_cell #(.MAX_RES(MAX_RES), .COUNT_BITS(COUNT_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .sel(sel), .res_cnt(nr),
      .res_idx(RB'(in_res)), .amount(amt), .req(req_r), .work(work_r),
      .need_o(cell_need[g]), .work_o(cell_work[g]), .fits_o(fits[g])
    );
  end

endmodule

/* tb/sv/bsc_checker.sv */
// Checker for the banker's safety check engine: mirrors tables and config,
// predicts result beats per accepted command, compares. Depends on bsc_pkg.
`timescale 1ns / 100ps
module bsc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [2:0] in_proc,
  input  logic [1:0] in_res,
  input  logic [7:0] in_amount,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_kind,
  input  logic [2:0] out_proc_id,
  input  logic       out_last_res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] proc_id;
    logic       last_res;
  } beat_t;

  beat_t      due_beats[$];
  logic [7:0] alloc_m[8][4];
  logic [7:0] need_m[8][4];
  logic [7:0] avail_m[4];
  logic [7:0] req_m[4];
  logic [3:0] procs_reg;
  logic [2:0] res_reg;

  function automatic int eff_procs();
    if (procs_reg == 0) return 1;
    if (procs_reg > 8) return 8;
    return int'(procs_reg);
  endfunction

  function automatic int eff_res();
    if (res_reg == 0) return 1;
    if (res_reg > 4) return 4;
    return int'(res_reg);
  endfunction

  // Scan processes cyclically, queue the finish order or one unsafe beat.
  task automatic run_safety();
    int n, r, i, cnt, idle, s;
    logic [7:0] work[4];
    logic fin[8];
    logic [2:0] order[8];
    logic fits;
    beat_t b;
    n = eff_procs(); r = eff_res(); i = 0; cnt = 0; idle = 0;
    for (int j = 0; j < 4; j++) work[j] = avail_m[j];
    for (int k = 0; k < 8; k++) fin[k] = 1'b0;
    while (cnt < n && idle < n) begin
      fits = !fin[i];
      for (int j = 0; j < r; j++) if (need_m[i][j] > work[j]) fits = 1'b0;
      if (fits) begin
        for (int j = 0; j < r; j++) begin
          s = int'(work[j]) + int'(alloc_m[i][j]);
          work[j] = (s > 255) ? 8'd255 : s[7:0];
        end
        fin[i] = 1'b1;
        order[cnt] = i[2:0];
        cnt++;
        idle = 0;
      end else begin
        idle++;
      end
      i = (i + 1) % n;
    end
    if (cnt < n) begin
      b.kind = bsc_pkg::KIND_UNSAFE; b.proc_id = '0; b.last_res = 1'b1;
      due_beats.push_back(b);
    end else begin
      for (int k = 0; k < n; k++) begin
        b.kind = bsc_pkg::KIND_SAFE; b.proc_id = order[k]; b.last_res = (k == n - 1);
        due_beats.push_back(b);
      end
    end
  endtask

  task automatic push_reject();
    beat_t b;
    b.kind = bsc_pkg::KIND_REJECT; b.proc_id = '0; b.last_res = 1'b1;
    due_beats.push_back(b);
  endtask

  // Apply one accepted command beat to the mirrored state.
  task automatic apply_cmd(logic [2:0] c, logic [2:0] p, logic [1:0] rs,
                           logic [7:0] amt, logic lst);
    int r, s;
    logic bad;
    case (c)
      bsc_pkg::CMD_LOAD_ALLOC: alloc_m[p][rs] = amt;
      bsc_pkg::CMD_LOAD_MAX:
        need_m[p][rs] = (amt > alloc_m[p][rs]) ? amt - alloc_m[p][rs] : 8'd0;
      bsc_pkg::CMD_LOAD_AVAIL: avail_m[rs] = amt;
      bsc_pkg::CMD_CHECK:      run_safety();
      bsc_pkg::CMD_REQUEST: begin
        req_m[rs] = amt;
        if (lst) begin
          r = eff_res();
          bad = (p >= eff_procs());
          for (int j = 0; j < r; j++)
            if (req_m[j] > need_m[p][j] || req_m[j] > avail_m[j]) bad = 1'b1;
          if (bad) begin
            push_reject();
          end else begin
            for (int j = 0; j < r; j++) begin
              s = int'(alloc_m[p][j]) + int'(req_m[j]);
              avail_m[j] = avail_m[j] - req_m[j];
              alloc_m[p][j] = (s > 255) ? 8'd255 : s[7:0];
              need_m[p][j] = need_m[p][j] - req_m[j];
            end
            run_safety();
          end
        end
      end
      default: ;
    endcase
  endtask

  // Track state and compare result beats at each rising edge.
  always @(posedge clk) begin
    beat_t e;
    if (!rst_n) begin
      for (int a = 0; a < 8; a++)
        for (int j = 0; j < 4; j++) begin
          alloc_m[a][j] = '0; need_m[a][j] = '0;
        end
      for (int j = 0; j < 4; j++) begin
        avail_m[j] = '0; req_m[j] = '0;
      end
      procs_reg = 4'd8;
      res_reg = 3'd4;
      due_beats.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bsc_pkg::CFG_NUM_PROCS) procs_reg = cfg_data;
        else if (cfg_index == bsc_pkg::CFG_NUM_RES) res_reg = cfg_data[2:0];
      end
      if (out_valid && !out_stall) begin
        if (due_beats.size() == 0) begin
          $error("unexpected result beat kind=%0d proc_id=%0d", out_kind, out_proc_id);
          fail_count++;
        end else begin
          e = due_beats.pop_front();
          if (e.kind !== out_kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_kind); fail_count++;
          end
          if (e.proc_id !== out_proc_id) begin
            $error("proc_id: expected %0d, got %0d", e.proc_id, out_proc_id); fail_count++;
          end
          if (e.last_res !== out_last_res) begin
            $error("last_res: expected %0d, got %0d", e.last_res, out_last_res);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        apply_cmd(in_cmd, in_proc, in_res, in_amount, in_last);
    end
    pending = due_beats.size();
  end
endmodule

/* tb/sv/tb.sv */
// Top of the banker's safety check testbench: clock, reset, command stimulus,
// config phases and verdict. Depends on bsc_pkg, bsc_checker and the block.
`timescale 1ns / 100ps
module tb;

  logic       clk, rst_n;
  logic       in_valid, in_stall, in_last;
  logic [2:0] in_cmd, in_proc;
  logic [1:0] in_res;
  logic [7:0] in_amount;
  logic       out_valid, out_stall, out_last_res;
  logic [1:0] out_kind;
  logic [2:0] out_proc_id;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;
  int         fail_count, pending;
  int         idle_cycles;
  int         in_idle_pct, out_idle_pct;
  logic       req_written[4];

  bankers_safety_check dut (.*);

  bsc_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Randomly stall the result channel.
  always @(negedge clk) out_stall <= ($urandom_range(99) < out_idle_pct);

  // Watchdog: no accepted beat for too long ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("** bankers_safety_check: FAILED **");
      $finish;
    end
  end

  // Send one command beat, with a random gap first; valid stays high on return
  // so the next beat can follow with no gap.
  task automatic send_cmd(logic [2:0] c, logic [2:0] p, logic [1:0] rs,
                          logic [7:0] amt, logic lst);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_cmd <= c; in_proc <= p; in_res <= rs;
    in_amount <= amt; in_last <= lst;
    if (c == bsc_pkg::CMD_REQUEST) req_written[rs] = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, wait until every predicted beat has come, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [3:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Request vector for one process: elements 0 to nres-1, last one flagged.
  task automatic send_request(logic [2:0] p, int nres, int maxamt);
    for (int j = 0; j < nres; j++)
      send_cmd(bsc_pkg::CMD_REQUEST, p, j[1:0], 8'($urandom_range(maxamt)), j == nres - 1);
  endtask

  // Fill tables with a random but plausible scenario.
  task automatic load_scene(int maxamt);
    for (int a = 0; a < 8; a++)
      for (int j = 0; j < 4; j++) begin
        send_cmd(bsc_pkg::CMD_LOAD_ALLOC, a[2:0], j[1:0], 8'($urandom_range(maxamt)), 1'b0);
        send_cmd(bsc_pkg::CMD_LOAD_MAX, a[2:0], j[1:0], 8'($urandom_range(2 * maxamt)),
                 1'b0);
      end
    for (int j = 0; j < 4; j++)
      send_cmd(bsc_pkg::CMD_LOAD_AVAIL, 3'd0, j[1:0], 8'($urandom_range(2 * maxamt)), 1'b0);
  endtask

  initial begin
    int pick, nres;
    rst_n = 1'b0; in_valid = 1'b0; in_cmd = '0; in_proc = '0; in_res = '0;
    in_amount = '0; in_last = 1'b0; out_stall = 1'b0; cfg_we = 1'b0;
    cfg_index = '0; cfg_data = '0; idle_cycles = 0;
    in_idle_pct = 27; out_idle_pct = 27;
    for (int j = 0; j < 4; j++) req_written[j] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every command, unknown codes, saturation cases.
    send_cmd(bsc_pkg::CMD_CHECK, 3'd0, 2'd0, 8'd0, 1'b0);
    send_cmd(bsc_pkg::CMD_LOAD_ALLOC, 3'd7, 2'd3, 8'd255, 1'b0);
    send_cmd(bsc_pkg::CMD_LOAD_MAX, 3'd7, 2'd3, 8'd10, 1'b0);
    send_cmd(bsc_pkg::CMD_LOAD_ALLOC, 3'd0, 2'd0, 8'd200, 1'b0);
    send_cmd(bsc_pkg::CMD_LOAD_MAX, 3'd0, 2'd0, 8'd255, 1'b0);
    send_cmd(bsc_pkg::CMD_LOAD_AVAIL, 3'd0, 2'd0, 8'd255, 1'b0);
    send_cmd(bsc_pkg::CMD_LOAD_AVAIL, 3'd0, 2'd3, 8'd0, 1'b0);
    send_cmd(bsc_pkg::CMD_CHECK, 3'd5, 2'd2, 8'd170, 1'b1);
    send_cmd(3'd5, 3'd2, 2'd1, 8'd85, 1'b1);
    send_cmd(3'd6, 3'd7, 2'd3, 8'd255, 1'b0);
    send_cmd(3'd7, 3'd0, 2'd0, 8'd0, 1'b1);
    send_request(3'd0, 4, 0);
    send_cmd(bsc_pkg::CMD_REQUEST, 3'd0, 2'd0, 8'd30, 1'b1);
    send_cmd(bsc_pkg::CMD_REQUEST, 3'd0, 2'd0, 8'd255, 1'b1);
    send_cmd(bsc_pkg::CMD_LOAD_MAX, 3'd3, 2'd1, 8'd255, 1'b0);
    send_cmd(bsc_pkg::CMD_LOAD_AVAIL, 3'd0, 2'd1, 8'd255, 1'b0);
    send_cmd(bsc_pkg::CMD_CHECK, 3'd0, 2'd0, 8'd0, 1'b0);
    drain();

    // Out-of-range registers, then an inactive-process request.
    write_cfg(bsc_pkg::CFG_NUM_PROCS, 4'd15);
    write_cfg(bsc_pkg::CFG_NUM_RES, 4'd7);
    send_cmd(bsc_pkg::CMD_CHECK, 3'd0, 2'd0, 8'd0, 1'b0);
    drain();
    write_cfg(bsc_pkg::CFG_NUM_PROCS, 4'd0);
    write_cfg(bsc_pkg::CFG_NUM_RES, 4'd0);
    send_cmd(bsc_pkg::CMD_CHECK, 3'd0, 2'd0, 8'd0, 1'b0);
    send_cmd(bsc_pkg::CMD_REQUEST, 3'd7, 2'd0, 8'd0, 1'b1);
    send_cmd(bsc_pkg::CMD_REQUEST, 3'd0, 2'd0, 8'd0, 1'b1);
    drain();

    // Random phases over several settings; phase 2 has no idling at all.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_cfg(bsc_pkg::CFG_NUM_PROCS, 4'd8); write_cfg(bsc_pkg::CFG_NUM_RES, 4'd4);
        end
        1: begin
          write_cfg(bsc_pkg::CFG_NUM_PROCS, 4'd1); write_cfg(bsc_pkg::CFG_NUM_RES, 4'd1);
        end
        default: begin
          write_cfg(bsc_pkg::CFG_NUM_PROCS, 4'($urandom_range(15)));
          write_cfg(bsc_pkg::CFG_NUM_RES, 4'($urandom_range(7)));
        end
      endcase
      if (ph == 2) begin in_idle_pct = 0; out_idle_pct = 0; end
      else begin in_idle_pct = 27; out_idle_pct = 27; end
      nres = 4;
      load_scene(ph == 3 ? 255 : 6);
      for (int k = 0; k < 16; k++) begin
        pick = $urandom_range(99);
        if (pick < 55)
          send_request(3'($urandom_range(7)), nres, ph == 3 ? 255 : 4);
        else if (pick < 75)
          send_cmd(bsc_pkg::CMD_CHECK, 3'($urandom), 2'($urandom), 8'($urandom),
                   1'($urandom));
        else if (pick < 85)
          send_cmd(bsc_pkg::CMD_LOAD_AVAIL, 3'($urandom), 2'($urandom),
                   8'($urandom_range(12)), 1'b0);
        else if (pick < 92)
          send_cmd(3'($urandom_range(1)), 3'($urandom), 2'($urandom),
                   8'($urandom_range(10)), 1'b0);
        else if (req_written[0] && req_written[1] && req_written[2] && req_written[3])
          send_cmd(bsc_pkg::CMD_REQUEST, 3'($urandom), 2'($urandom), 8'($urandom),
                   1'($urandom));
        else
          send_cmd(3'($urandom_range(7, 5)), 3'($urandom), 2'($urandom), 8'($urandom),
                   1'($urandom));
        // Sender hold-off until all results are back, once per phase.
        if (k == 8) begin
          in_valid <= 1'b0;
          do @(negedge clk); while (pending != 0);
        end
      end
      drain();
    end

    if (fail_count == 0)
      $display("** bankers_safety_check: PASSED **");
    else
      $display("** bankers_safety_check: FAILED **");
    $finish;
  end
endmodule
